// ===== rtl/core/csm_pkg.sv =====
// Package for the CSR sparse matrix store: size defaults, status codes and request codes.
// Depends on nothing; used by rtl/core/csr_sparse_matrix_store.sv and by the sim checker and testbench.
`default_nettype none

package csm_pkg;

   localparam int unsigned MAX_ORDER_DEFAULT   = 256;
   localparam int unsigned MAX_ENTRIES_DEFAULT = 1024;

   localparam int unsigned INDEX_WIDTH  = 8;
   localparam int unsigned VALUE_WIDTH  = 64;
   localparam int unsigned ORDER_WIDTH  = 9;
   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 9'd256;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_READ  = 1'b0,
      REQ_WRITE = 1'b1
   } req_kind_type;

endpackage

`default_nettype wire

// ===== rtl/core/csr_sparse_matrix_store.sv =====
// Top level of the CSR sparse matrix store: row pointer memory, entry memory and sequencer.
// Depends on csm_pkg (rtl/core/csm_pkg.sv).
`default_nettype none

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------------
// req       | in        | req_valid/req_stall  | req_type, req_row_index, req_column_index,
//           |           |                      | req_write_value
// rsp       | out       | rsp_valid/rsp_stall  | rsp_read_value, rsp_found, rsp_status
// csr       | in        | csr_valid/csr_ready  | csr_matrix_order
//
// One transaction is worked at a time. A zero write or a range error goes from acceptance
// straight to the done state; a read, miss or overwrite fetches row start and row end,
// scans the row's entries and ends in the done state. An insertion adds the shift of the
// entry memory from the top entry down to the insert point, the entry write and the pointer
// bump of every later row, all bound by the single read and write port of each.
// After reset all MAX_ORDER + 1 row pointers are cleared; req_stall stays high
// during that pass. A finished result waits in an output register while rsp_stall is high.

module csr_sparse_matrix_store #(
   parameter int unsigned MAX_ORDER   = csm_pkg::MAX_ORDER_DEFAULT,
   parameter int unsigned MAX_ENTRIES = csm_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_type,
   input  wire  [csm_pkg::INDEX_WIDTH-1:0]      req_row_index,
   input  wire  [csm_pkg::INDEX_WIDTH-1:0]      req_column_index,
   input  wire  [csm_pkg::VALUE_WIDTH-1:0]      req_write_value,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [csm_pkg::VALUE_WIDTH-1:0]      rsp_read_value,
   output logic                                 rsp_found,
   output logic [1:0]                           rsp_status,
   // configuration channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [csm_pkg::ORDER_WIDTH-1:0]      csr_matrix_order
);

   // pointer/count width, entry address width, row address width
   localparam int unsigned PW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned RW = $clog2(MAX_ORDER + 1);
   localparam int unsigned IW = csm_pkg::INDEX_WIDTH;
   localparam int unsigned VW = csm_pkg::VALUE_WIDTH;
   localparam int unsigned DW = IW + VW;   // entry word: {column, value}

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_ROW0   = 9'b000000100,
      S_ROW1   = 9'b000001000,
      S_SCAN   = 9'b000010000,
      S_SHIFT  = 9'b000100000,
      S_INSERT = 9'b001000000,
      S_BUMP   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   // memories
   logic [PW-1:0] row_mem [MAX_ORDER+1];
   logic [DW-1:0] ent_mem [MAX_ENTRIES];

   state_type                    state_ff, state_in;
   logic [csm_pkg::ORDER_WIDTH-1:0] order_ff;
   logic [PW-1:0]                cnt_ff, cnt_in;
   logic [PW-1:0]                k_ff, k_in;       // scan / insert position
   logic [PW-1:0]                ke_ff, ke_in;     // row end
   logic [EW-1:0]                j_ff, j_in;       // shift source
   logic [RW-1:0]                q_ff, q_in;       // row pointer sweep
   logic                         wr_ff, wr_in;
   logic [IW-1:0]                row_ff, row_in;
   logic [IW-1:0]                col_ff, col_in;
   logic [VW-1:0]                val_ff, val_in;
   logic [VW-1:0]                res_value_ff, res_value_in;
   logic                         res_found_ff, res_found_in;
   csm_pkg::status_type          res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   // output register, held while the result waits
   logic [VW-1:0]                rsp_value_ff;
   logic                         rsp_found_ff;
   csm_pkg::status_type          rsp_status_ff;

   // memory ports
   logic [RW-1:0] row_raddr, row_waddr;
   logic [PW-1:0] row_wdata, row_rdata_ff;
   logic          row_we;
   logic [EW-1:0] ent_raddr, ent_waddr;
   logic [DW-1:0] ent_wdata, ent_rdata_ff;
   logic          ent_we;

   logic          req_accept, rsp_free;
   logic          zero_write, out_of_range;
   logic [IW-1:0] scan_col;
   logic          in_row;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // Writes of either signed zero are dropped before any range check.
   assign zero_write = (req_type == csm_pkg::REQ_WRITE) && (req_write_value[VW-2:0] == '0);
   // Indices at or above the order register or MAX_ORDER are out of range; order zero puts every index out of range.
   assign out_of_range = ({1'b0, req_row_index} >= order_ff)
                      || ({1'b0, req_column_index} >= order_ff)
                      || (32'(req_row_index) >= MAX_ORDER)
                      || (32'(req_column_index) >= MAX_ORDER);

   assign scan_col = ent_rdata_ff[DW-1:VW];
   assign in_row   = (k_ff < ke_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      ke_in         = ke_ff;
      j_in          = j_ff;
      q_in          = q_ff;
      wr_in         = wr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      row_raddr     = q_ff;
      row_waddr     = q_ff;
      row_wdata     = '0;
      row_we        = 1'b0;
      ent_raddr     = EW'(k_ff);
      ent_waddr     = EW'(k_ff);
      ent_wdata     = {col_ff, val_ff};
      ent_we        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // sweep the row pointers to zero
            row_we = 1'b1;
            q_in   = q_ff + RW'(1);
            if (q_ff == RW'(MAX_ORDER)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            row_raddr = RW'(req_row_index);
            if (req_accept) begin
               wr_in         = req_type;
               row_in        = req_row_index;
               col_in        = req_column_index;
               val_in        = req_write_value;
               res_value_in  = '0;
               res_found_in  = 1'b0;
               res_status_in = csm_pkg::STATUS_OK;
               if (zero_write) begin
                  state_in = S_DONE;
               end else if (out_of_range) begin
                  res_status_in = csm_pkg::STATUS_RANGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_ROW0;
               end
            end
         end
         S_ROW0: begin
            // row start arrives; fetch row end
            k_in      = row_rdata_ff;
            row_raddr = RW'(row_ff) + RW'(1);
            state_in  = S_ROW1;
         end
         S_ROW1: begin
            // row end arrives; fetch first entry of the row
            ke_in     = row_rdata_ff;
            ent_raddr = EW'(k_ff);
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (in_row && (scan_col < col_ff)) begin
               // advance one entry per cycle
               k_in      = k_ff + PW'(1);
               ent_raddr = EW'(k_ff + PW'(1));
            end else if (in_row && (scan_col == col_ff)) begin
               res_found_in = 1'b1;
               if (wr_ff == csm_pkg::REQ_WRITE) begin
                  ent_we = 1'b1;
               end else begin
                  res_value_in = ent_rdata_ff[VW-1:0];
               end
               state_in = S_DONE;
            end else if (wr_ff == csm_pkg::REQ_READ) begin
               state_in = S_DONE;
            end else if (32'(cnt_ff) >= MAX_ENTRIES) begin
               res_status_in = csm_pkg::STATUS_FULL;
               state_in      = S_DONE;
            end else if (cnt_ff > k_ff) begin
               // shift from the top entry down to the insert point
               ent_raddr = EW'(cnt_ff - PW'(1));
               j_in      = EW'(cnt_ff - PW'(1));
               state_in  = S_SHIFT;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_SHIFT: begin
            // move entry j up by one while fetching j-1
            ent_we    = 1'b1;
            ent_waddr = j_ff + EW'(1);
            ent_wdata = ent_rdata_ff;
            if (j_ff == EW'(k_ff)) begin
               state_in = S_INSERT;
            end else begin
               ent_raddr = j_ff - EW'(1);
               j_in      = j_ff - EW'(1);
            end
         end
         S_INSERT: begin
            ent_we    = 1'b1;
            cnt_in    = cnt_ff + PW'(1);
            row_raddr = RW'(row_ff) + RW'(1);
            q_in      = RW'(row_ff) + RW'(1);
            state_in  = S_BUMP;
         end
         S_BUMP: begin
            // increment every later row pointer, read ahead one row
            row_we    = 1'b1;
            row_wdata = row_rdata_ff + PW'(1);
            if (q_ff == RW'(MAX_ORDER)) begin
               state_in = S_DONE;
            end else begin
               row_raddr = q_ff + RW'(1);
               q_in      = q_ff + RW'(1);
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         order_ff     <= csm_pkg::ORDER_RESET;
         cnt_ff       <= '0;
         q_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         q_ff         <= q_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            order_ff <= csr_matrix_order;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      ke_ff         <= ke_in;
      j_ff          <= j_in;
      wr_ff         <= wr_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      // load the output register only when the finished result is handed over
      if ((state_ff == S_DONE) && rsp_free) begin
         rsp_value_ff  <= res_value_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // row pointer memory
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rdata_ff <= row_mem[row_raddr];
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;

   // the entry count never passes the memory depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_ENTRIES)
      else $error("entry count above capacity");

   // an insertion only starts with room left
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (32'(cnt_ff) < MAX_ENTRIES))
      else $error("insert into full store");

   // the shift never runs below the insert point
   a_shift_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (32'(j_ff) >= 32'(k_ff)))
      else $error("shift below insert point");

   // a new result only follows the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result without completed transaction");

   // a hit always reports ok
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_status_ff == csm_pkg::STATUS_OK))
      else $error("hit with error status");

endmodule

`default_nettype wire

// ===== sim/csm_checker.sv =====
// Checker for the CSR sparse matrix store: mirrors the row pointers and entry lists,
// predicts each response and compares it. Depends on csm_pkg.
`timescale 1ns / 100ps

module csm_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire         req_type,
   input  wire  [7:0]  req_row_index,
   input  wire  [7:0]  req_column_index,
   input  wire  [63:0] req_write_value,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [63:0] rsp_read_value,
   input  wire         rsp_found,
   input  wire  [1:0]  rsp_status,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire  [8:0]  csr_matrix_order,
   output int          fail_count,
   output int          pending_count
);

   localparam int ORDER_MAX = 256;
   localparam int ENTRY_MAX = 1024;

   typedef struct packed {
      logic [63:0] value;
      logic        hit;
      logic [1:0]  status;
   } answer_type;

   int          row_ptr[ORDER_MAX + 1];
   logic [7:0]  col_of[ENTRY_MAX];
   logic [63:0] val_of[ENTRY_MAX];
   int          stored;
   int          order;
   answer_type  answers[$];

   assign pending_count = answers.size();

   function automatic answer_type lookup_or_insert(logic wr, int r, int c, logic [63:0] v);
      answer_type a;
      int ks, ke, k;
      a = '0;
      a.status = csm_pkg::STATUS_OK;
      if (wr == csm_pkg::REQ_WRITE && v[62:0] == 63'd0) return a;
      if (r >= order || c >= order) begin
         a.status = csm_pkg::STATUS_RANGE;
         return a;
      end
      ks = row_ptr[r] > stored ? stored : row_ptr[r];
      ke = row_ptr[r + 1] > stored ? stored : row_ptr[r + 1];
      if (ke < ks) ke = ks;
      k = ks;
      while (k < ke && col_of[k] < c) k++;
      if (k < ke && col_of[k] == c) begin
         a.hit = 1'b1;
         if (wr == csm_pkg::REQ_WRITE) val_of[k] = v;
         else a.value = val_of[k];
         return a;
      end
      if (wr == csm_pkg::REQ_READ) return a;
      if (stored >= ENTRY_MAX) begin
         a.status = csm_pkg::STATUS_FULL;
         return a;
      end
      for (int j = stored; j > k; j--) begin
         col_of[j] = col_of[j - 1];
         val_of[j] = val_of[j - 1];
      end
      col_of[k] = 8'(c);
      val_of[k] = v;
      stored++;
      for (int q = r + 1; q <= ORDER_MAX; q++) row_ptr[q]++;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         foreach (row_ptr[i]) row_ptr[i] = 0;
         stored = 0;
         order = ORDER_MAX;
         answers.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready)
            order = csr_matrix_order > ORDER_MAX ? ORDER_MAX : csr_matrix_order;
         if (req_valid && !req_stall)
            answers.push_back(lookup_or_insert(req_type, req_row_index, req_column_index,
                                               req_write_value));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_read_value, rsp_found, rsp_status};
            if (answers.size() == 0) begin
               $error("unexpected response transaction");
               errs++;
            end else begin
               want = answers.pop_front();
               if (got.value !== want.value) begin
                  $error("read_value expected %h actual %h", want.value, got.value);
                  errs++;
               end
               if (got.hit !== want.hit) begin
                  $error("found expected %b actual %b", want.hit, got.hit);
                  errs++;
               end
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== sim/tb_csr_sparse_matrix_store.sv =====
// Testbench top for the CSR sparse matrix store: clock, reset, stimulus and verdict.
// Depends on csm_pkg, csr_sparse_matrix_store and csm_checker.
`timescale 1ns / 100ps

module tb_csr_sparse_matrix_store;

   // inserts shift the entry memory and bump the row pointers; leave plenty of room for stalls on top
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 1400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_type = csm_pkg::REQ_READ;
   logic [7:0]  req_row_index = '0;
   logic [7:0]  req_column_index = '0;
   logic [63:0] req_write_value = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic [8:0]  csr_matrix_order = '0;
   wire         req_stall, rsp_valid, rsp_found, csr_ready;
   wire  [63:0] rsp_read_value;
   wire  [1:0]  rsp_status;
   int          fail_count, pending_count;
   int          quiet_cycles = 0;
   logic        calm = 1'b0;   // long stretch with no idling on either side

   csr_sparse_matrix_store u_dut (.*);
   csm_checker u_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort when no transaction of any kind moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("csr_sparse_matrix_store verification failed");
         $finish;
      end
   end

   // Stall the response side at random, about 12 percent of the time, except in calm stretches.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 12);
   end

   // Send one request; idle first at random, hold the payload until accepted.
   task automatic send_request(logic wr, logic [7:0] r, logic [7:0] c, logic [63:0] v);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= wr;
      req_row_index    <= r;
      req_column_index <= c;
      req_write_value  <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_order(logic [8:0] n);
      go_idle();
      csr_valid        <= 1'b1;
      csr_matrix_order <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (v[62:0] == 63'd0) v[0] = 1'b1;
      return v;
   endfunction

   // Mostly writes and reads in a window of span rows and columns so hits, overwrites and inserts mix.
   task automatic random_phase(int count, int span);
      logic [7:0] r, c;
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 2 && i < count / 2 + 40);
         r = 8'($urandom_range(span - 1));
         c = 8'($urandom_range(span - 1));
         case ($urandom_range(9))
            0:       send_request(csm_pkg::REQ_WRITE, r, c, {1'($urandom_range(1)), 63'd0});
            1:       send_request(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                                  rand_value());
            2, 3, 4: send_request(csm_pkg::REQ_WRITE, r, c, rand_value());
            default: send_request(csm_pkg::REQ_READ, r, c, rand_value());
         endcase
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero writes, overwrite, hit, miss, range.
      send_request(csm_pkg::REQ_READ,  8'd0,   8'd0,   '0);
      send_request(csm_pkg::REQ_WRITE, 8'd0,   8'd0,   64'hFFFF_FFFF_FFFF_FFFF);
      send_request(csm_pkg::REQ_WRITE, 8'd255, 8'd255, 64'h8000_0000_0000_0001);
      send_request(csm_pkg::REQ_WRITE, 8'd255, 8'd0,   64'h3FF0_0000_0000_0000);
      send_request(csm_pkg::REQ_WRITE, 8'd5,   8'd7,   64'h0000_0000_0000_0000);
      send_request(csm_pkg::REQ_WRITE, 8'd5,   8'd7,   64'h8000_0000_0000_0000);
      send_request(csm_pkg::REQ_READ,  8'd5,   8'd7,   '1);
      send_request(csm_pkg::REQ_WRITE, 8'd0,   8'd0,   64'h5555_AAAA_5555_AAAA);
      send_request(csm_pkg::REQ_READ,  8'd0,   8'd0,   '0);
      send_request(csm_pkg::REQ_READ,  8'd255, 8'd255, '0);
      send_request(csm_pkg::REQ_READ,  8'd255, 8'd0,   '0);
      send_request(csm_pkg::REQ_WRITE, 8'd0,   8'd255, 64'hAAAA_5555_AAAA_5555);
      send_request(csm_pkg::REQ_READ,  8'd0,   8'd128, '0);

      set_order(9'd1);
      send_request(csm_pkg::REQ_READ,  8'd0, 8'd0, '0);
      send_request(csm_pkg::REQ_WRITE, 8'd1, 8'd0, 64'd9);
      send_request(csm_pkg::REQ_READ,  8'd0, 8'd1, '0);
      set_order(9'd0);
      send_request(csm_pkg::REQ_READ,  8'd0, 8'd0, '0);
      send_request(csm_pkg::REQ_WRITE, 8'd0, 8'd0, 64'd3);
      set_order(9'd511);   // above the maximum, acts as 256
      send_request(csm_pkg::REQ_READ,  8'd255, 8'd255, '0);

      set_order(9'd16);
      random_phase(150, 20);
      set_order(9'd256);
      random_phase(120, 256);

      // Pack the first rows densely, then overwrite and read back.
      set_order(9'd64);
      for (int i = 0; i < 80; i++)
         send_request(csm_pkg::REQ_WRITE, 8'(i / 32), 8'(i % 32 * 2), rand_value());
      send_request(csm_pkg::REQ_WRITE, 8'd0, 8'd0, 64'h1234_5678_9ABC_DEF0);
      send_request(csm_pkg::REQ_READ,  8'd0, 8'd0, '0);
      random_phase(90, 64);

      go_idle();
      if (fail_count == 0) begin
         $display("csr_sparse_matrix_store verification clean");
      end else begin
         $display("csr_sparse_matrix_store verification failed");
      end
      $finish;
   end

endmodule
